### hdl/gsc_pkg.sv
// shared types, constants and helpers of the gamepad to servo command mapper
package gsc_pkg;

  localparam int unsigned AddrW = 5;

  localparam logic [15:0] OP_KEY        = 16'd1;
  localparam logic [15:0] OP_ABS        = 16'd3;
  localparam logic [15:0] KEY_OPTION    = 16'd315;
  localparam logic [15:0] KEY_FIRE      = 16'd311;
  localparam logic [15:0] AXIS_BRAKE    = 16'd2;
  localparam logic [15:0] AXIS_THROTTLE = 16'd5;
  localparam logic [15:0] AXIS_STICK    = 16'd3;

  localparam logic [2:0] REG_MOTOR_CENTER   = 3'd0;
  localparam logic [2:0] REG_MOTOR_SPAN     = 3'd1;
  localparam logic [2:0] REG_MOTOR_JUMP     = 3'd2;
  localparam logic [2:0] REG_STEER_MIN      = 3'd3;
  localparam logic [2:0] REG_STEER_MAX      = 3'd4;
  localparam logic [2:0] REG_STICK_LOW      = 3'd5;
  localparam logic [2:0] REG_STICK_HIGH     = 3'd6;
  localparam logic [2:0] REG_GUN_ACTIVE     = 3'd7;

  localparam logic [6:0] PCT_MID  = 7'd50;
  localparam logic [7:0] STICK_RST = 8'd127;

  // floor(m / 100) = (m * RECIP_100) >> 26 and floor(m / 50) = (m * RECIP_50) >> 25
  localparam logic [19:0] RECIP_100 = 20'd671089;
  localparam logic [19:0] RECIP_50  = 20'd671089;

  typedef struct packed {
    logic [11:0] motor_center;
    logic [10:0] motor_span;
    logic [10:0] motor_jump;
    logic [11:0] steer_min;
    logic [11:0] steer_max;
    logic [7:0]  stick_low;
    logic [7:0]  stick_high;
    logic        gun_active_level;
  } cfg_t;

  typedef struct packed {
    logic [15:0] opcode;
    logic [15:0] event_code;
    logic [7:0]  event_value;
  } in_req_t;

  typedef struct packed {
    logic [12:0] motor_pulse;
    logic [12:0] steer_pulse;
    logic        gun_level;
    logic [6:0]  speed_percent;
    logic [6:0]  steer_percent;
    logic        is_stop;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic calc_pct;
    logic calc_prod;
    logic calc_div;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic stop;
    logic out_free;
  } sts_t;

  // floor(n / 255), exact for n below 65280
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] s;
    s = {1'b0, n} + 17'(n[15:8]) + 17'd1;
    return 8'(s >> 8);
  endfunction

endpackage

### hdl/gsc_regs.sv
// configuration register file with apb access
module gsc_regs import gsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MOTOR_CENTER:   cfg_d.motor_center     = pwdata[11:0];
        REG_MOTOR_SPAN:     cfg_d.motor_span       = pwdata[10:0];
        REG_MOTOR_JUMP:     cfg_d.motor_jump       = pwdata[10:0];
        REG_STEER_MIN:      cfg_d.steer_min        = pwdata[11:0];
        REG_STEER_MAX:      cfg_d.steer_max        = pwdata[11:0];
        REG_STICK_LOW:      cfg_d.stick_low        = pwdata[7:0];
        REG_STICK_HIGH:     cfg_d.stick_high       = pwdata[7:0];
        REG_GUN_ACTIVE:     cfg_d.gun_active_level = pwdata[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MOTOR_CENTER:   prdata = {20'd0, cfg_q.motor_center};
      REG_MOTOR_SPAN:     prdata = {21'd0, cfg_q.motor_span};
      REG_MOTOR_JUMP:     prdata = {21'd0, cfg_q.motor_jump};
      REG_STEER_MIN:      prdata = {20'd0, cfg_q.steer_min};
      REG_STEER_MAX:      prdata = {20'd0, cfg_q.steer_max};
      REG_STICK_LOW:      prdata = {24'd0, cfg_q.stick_low};
      REG_STICK_HIGH:     prdata = {24'd0, cfg_q.stick_high};
      REG_GUN_ACTIVE:     prdata = {31'd0, cfg_q.gun_active_level};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motor_center     <= 12'd1500;
      cfg_q.motor_span       <= 11'd500;
      cfg_q.motor_jump       <= 11'd60;
      cfg_q.steer_min        <= 12'd820;
      cfg_q.steer_max        <= 12'd1480;
      cfg_q.stick_low        <= 8'd119;
      cfg_q.stick_high       <= 8'd133;
      cfg_q.gun_active_level <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hdl/gsc_ctrl.sv
// controller state machine sequencing one request through the datapath
module gsc_ctrl import gsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PCT   = 5'b00010,
    S_PROD  = 5'b00100,
    S_DIV   = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PCT;
        end
      end
      S_PCT: begin
        cmd_o.calc_pct = 1'b1;
        if (!sts_i.emit) begin
          state_d = S_IDLE;
        end else if (sts_i.stop) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.calc_prod = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.calc_div = 1'b1;
        state_d        = S_WRITE;
      end
      S_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.write_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("more than one datapath command");
  a_load_then_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.calc_pct) else $error("percent step missed after load");
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write_out |-> sts_i.out_free) else $error("result written over pending one");
`endif

endmodule

### hdl/gsc_datapath.sv
// datapath: held gamepad state, percent and pulse arithmetic, result register
module gsc_datapath import gsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  cmd_t     cmd_i,
  output sts_t     sts_o,
  input  in_req_t  in_req_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output out_rsp_t out_rsp_o
);

  logic paused_q, paused_d;
  logic fire_q, fire_d;
  logic [7:0] brake_q, brake_d;
  logic [7:0] throttle_q, throttle_d;
  logic [7:0] stick_q, stick_d;
  logic emit_q, emit_d;
  logic stop_q, stop_d;
  logic out_valid_q, out_valid_d;

  logic [6:0] st_pct_q, sp_pct_q;
  logic signed [20:0] steer_prod_q;
  logic signed [20:0] motor_n_q;
  logic motor_mid_q;
  logic [12:0] motor_pulse_q, steer_pulse_q;
  out_rsp_t out_q;

  // event decode
  logic option;
  always_comb begin
    paused_d   = paused_q;
    fire_d     = fire_q;
    brake_d    = brake_q;
    throttle_d = throttle_q;
    stick_d    = stick_q;
    emit_d     = emit_q;
    stop_d     = stop_q;
    option     = 1'b0;
    if (cmd_i.load) begin
      if (in_req_i.opcode == OP_KEY) begin
        if (in_req_i.event_code == KEY_OPTION) begin
          option = (in_req_i.event_value != 8'd0);
        end else if (in_req_i.event_code == KEY_FIRE) begin
          fire_d = (in_req_i.event_value != 8'd0);
        end
      end else if (in_req_i.opcode == OP_ABS) begin
        if (in_req_i.event_code == AXIS_BRAKE) begin
          brake_d = in_req_i.event_value;
        end else if (in_req_i.event_code == AXIS_THROTTLE) begin
          throttle_d = in_req_i.event_value;
        end else if (in_req_i.event_code == AXIS_STICK) begin
          stick_d = in_req_i.event_value;
        end
      end
      paused_d = paused_q ^ option;
      stop_d   = option;
      emit_d   = option ? !paused_q : !paused_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q   <= 1'b0;
      fire_q     <= 1'b0;
      brake_q    <= 8'd0;
      throttle_q <= 8'd0;
      stick_q    <= STICK_RST;
      emit_q     <= 1'b0;
      stop_q     <= 1'b0;
    end else begin
      paused_q   <= paused_d;
      fire_q     <= fire_d;
      brake_q    <= brake_d;
      throttle_q <= throttle_d;
      stick_q    <= stick_d;
      emit_q     <= emit_d;
      stop_q     <= stop_d;
    end
  end

  // percent step
  logic       in_band;
  logic [7:0] st_raw, thr_part, brk_part;
  always_comb begin
    in_band  = (stick_q >= cfg_i.stick_low) && (stick_q <= cfg_i.stick_high);
    st_raw   = div255(16'(stick_q) * 16'd100);
    thr_part = div255(16'(throttle_q) * 16'd50);
    brk_part = div255(16'(brake_q) * 16'd50 + 16'd254);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_pct) begin
      st_pct_q <= in_band ? PCT_MID : st_raw[6:0];
      sp_pct_q <= 7'(8'(PCT_MID) + thr_part - brk_part);
    end
  end

  // product step
  logic signed [12:0] steer_diff;
  logic [12:0]        c_plus_dz;
  logic signed [13:0] c_minus_dz;
  logic signed [11:0] rest;
  logic [6:0]         k;
  logic               up;
  logic signed [20:0] rest_k, base_up, base_dn;
  always_comb begin
    steer_diff = $signed({1'b0, cfg_i.steer_max}) - $signed({1'b0, cfg_i.steer_min});
    c_plus_dz  = {1'b0, cfg_i.motor_center} + {2'b0, cfg_i.motor_jump};
    c_minus_dz = $signed({2'b0, cfg_i.motor_center}) - $signed({3'b0, cfg_i.motor_jump});
    rest       = $signed({1'b0, cfg_i.motor_span}) - $signed({1'b0, cfg_i.motor_jump});
    up         = (sp_pct_q > PCT_MID);
    k          = up ? (sp_pct_q - PCT_MID) : (PCT_MID - sp_pct_q);
    rest_k     = rest * $signed({1'b0, k});
    base_up    = $signed({8'd0, c_plus_dz}) * 21'sd50;
    base_dn    = $signed({{7{c_minus_dz[13]}}, c_minus_dz}) * 21'sd50;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_prod) begin
      steer_prod_q <= steer_diff * $signed({1'b0, st_pct_q});
      motor_n_q    <= up ? (base_up + rest_k) : (base_dn - rest_k);
      motor_mid_q  <= (sp_pct_q == PCT_MID);
    end
  end

  // reciprocal divide step
  logic [19:0]        steer_mag, motor_mag;
  logic [39:0]        steer_mult, motor_mult;
  logic [12:0]        steer_q;
  logic signed [13:0] steer_sum;
  logic [12:0]        motor_res;
  always_comb begin
    steer_mag  = steer_prod_q[20] ? 20'(-steer_prod_q) : steer_prod_q[19:0];
    steer_mult = 40'(steer_mag) * 40'(RECIP_100);
    steer_q    = steer_mult[38:26];
    steer_sum  = steer_prod_q[20] ?
                 ($signed({2'b0, cfg_i.steer_min}) - $signed({1'b0, steer_q})) :
                 ($signed({2'b0, cfg_i.steer_min}) + $signed({1'b0, steer_q}));
    motor_mag  = motor_n_q[19:0];
    motor_mult = 40'(motor_mag) * 40'(RECIP_50);
    if (motor_mid_q) begin
      motor_res = {1'b0, cfg_i.motor_center};
    end else if (motor_n_q[20] || (motor_n_q == 21'sd0)) begin
      motor_res = 13'd0;
    end else begin
      motor_res = motor_mult[37:25];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_div) begin
      steer_pulse_q <= steer_sum[13] ? 13'd0 : steer_sum[12:0];
      motor_pulse_q <= motor_res;
    end
  end

  // result register
  out_rsp_t out_d;
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.write_out) begin
      out_valid_d = 1'b1;
    end
    if (stop_q) begin
      out_d.motor_pulse   = 13'd0;
      out_d.steer_pulse   = 13'd0;
      out_d.gun_level     = !cfg_i.gun_active_level;
      out_d.speed_percent = 7'd0;
      out_d.steer_percent = 7'd0;
      out_d.is_stop       = 1'b1;
    end else begin
      out_d.motor_pulse   = motor_pulse_q;
      out_d.steer_pulse   = steer_pulse_q;
      out_d.gun_level     = fire_q ? cfg_i.gun_active_level : !cfg_i.gun_active_level;
      out_d.speed_percent = sp_pct_q;
      out_d.steer_percent = st_pct_q;
      out_d.is_stop       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = out_q;
  assign sts_o.emit      = emit_q;
  assign sts_o.stop      = stop_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

`ifndef SYNTH
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_stop) |->
    (out_q.motor_pulse == 13'd0 && out_q.steer_pulse == 13'd0))
    else $error("stop result carries a pulse");
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_stop) |->
    (out_q.speed_percent <= 7'd100 && out_q.steer_percent <= 7'd100))
    else $error("percent out of range");
`endif

endmodule

### hdl/gamepad_to_servo_command_mapper_core.sv
// top level of the gamepad to servo command mapper
// drive results pass percent, product and divide steps, stop results percent only
// next request taken once back in idle: after a result write, or after percent if none
// the rate is set by the controller steps and by waiting for a free output register
// a finished result waits in the output register while the next request is taken
// rst_ni resets held state (stick to 127), pause, output valid and config registers
module gamepad_to_servo_command_mapper_core import gsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_req_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_rsp_t         out_rsp_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  gsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gsc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
